>>> design/fnp_pkg.sv
// fnp_pkg: shared types, character and result codes for the FASTA stream parser.
// No dependencies; imported by the parse core, the output buffer and the top level.
`default_nettype none

package fnp_pkg;

	// Counter widths; the result word is sized from these
	localparam int COUNT_BITS      = 32;
	localparam int HEADER_LEN_BITS = 16;

	// Characters the parser reacts to
	localparam logic [7:0] CHAR_GT         = 8'h3E;
	localparam logic [7:0] CHAR_NL         = 8'h0A;
	localparam logic [7:0] CHAR_SPACE      = 8'h20;
	localparam logic [7:0] CHAR_NUL        = 8'h00;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_ZERO       = 8'h30;
	localparam logic [7:0] CHAR_NINE       = 8'h39;

	// Result kinds
	localparam logic [2:0] KIND_HEADER = 3'd0;
	localparam logic [2:0] KIND_NT     = 3'd1;
	localparam logic [2:0] KIND_RECORD = 3'd2;
	localparam logic [2:0] KIND_FILE   = 3'd3;
	localparam logic [2:0] KIND_ERROR  = 3'd4;

	// Error codes
	localparam logic [1:0] ERR_BAD_START  = 2'd0;
	localparam logic [1:0] ERR_ILLEGAL    = 2'd1;
	localparam logic [1:0] ERR_MISSING_AB = 2'd2;
	localparam logic [1:0] ERR_NOT_SORTED = 2'd3;

	// Nucleotide codes; NT_NONE marks a byte that is not a nucleotide letter
	localparam logic [2:0] NT_NONE = 3'd0;
	localparam logic [2:0] NT_A    = 3'd1;
	localparam logic [2:0] NT_C    = 3'd2;
	localparam logic [2:0] NT_G    = 3'd3;
	localparam logic [2:0] NT_TU   = 3'd4;

	// Input word
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} fnp_in_t;

	// Result word
	typedef struct packed {
		logic [2:0]                 kind;
		logic [7:0]                 symbol;
		logic [HEADER_LEN_BITS-1:0] header_length;
		logic [COUNT_BITS-1:0]      sequence_length;
		logic [COUNT_BITS-1:0]      abundance;
		logic [COUNT_BITS-1:0]      record_count;
		logic [COUNT_BITS-1:0]      longest_length;
		logic [COUNT_BITS+7:0]      total_nucleotides;
		logic [1:0]                 error_code;
		logic [31:0]                line_number;
	} fnp_out_t;

	// Letter to nucleotide code, either case
	function automatic logic [2:0] nt_code(input logic [7:0] b);
		logic [2:0] code;
		unique case (b)
			8'h41, 8'h61:               code = NT_A;
			8'h43, 8'h63:               code = NT_C;
			8'h47, 8'h67:               code = NT_G;
			8'h54, 8'h74, 8'h55, 8'h75: code = NT_TU;
			default:                    code = NT_NONE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

>>> design/fnp_parse_core.sv
// fnp_parse_core: parser state registers and the one-byte next-state / result logic.
// Depends on fnp_pkg for codes, counter widths, the nucleotide table and the word types.
`default_nettype none

module fnp_parse_core import fnp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     fire,
	input  wire fnp_in_t  in_word,
	output logic          res_valid,
	output fnp_out_t      res
);

	localparam int CB = COUNT_BITS;
	localparam int HL = HEADER_LEN_BITS;
	localparam int TB = COUNT_BITS + 8;

	localparam logic [HL-1:0] HDR_ONE = HL'(1);
	localparam logic [CB-1:0] CNT_ONE = CB'(1);

	// Parser modes
	localparam logic [2:0] MODE_FILE_START  = 3'd0;
	localparam logic [2:0] MODE_HEADER_ID   = 3'd1;
	localparam logic [2:0] MODE_HEADER_REST = 3'd2;
	localparam logic [2:0] MODE_SEQ         = 3'd3;
	localparam logic [2:0] MODE_SEQ_SKIP    = 3'd4;
	localparam logic [2:0] MODE_HALTED      = 3'd5;

	logic [2:0]    mode_q, mode_d;
	logic          line_start_q, line_start_d;
	logic [HL-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [CB-1:0] acc_q, acc_d;
	logic          after_us_q, after_us_d;
	logic          digit_seen_q, digit_seen_d;
	logic [CB-1:0] seq_cnt_q, seq_cnt_d;
	logic [CB-1:0] prev_ab_q, prev_ab_d;
	logic          prev_valid_q, prev_valid_d;
	logic [31:0]   line_q, line_d;
	logic [CB-1:0] rec_q, rec_d;
	logic [CB-1:0] longest_q, longest_d;
	logic [TB-1:0] total_q, total_d;

	logic [7:0]    b;
	logic [2:0]    code;
	logic [CB+3:0] acc_mul;
	logic [CB-1:0] acc_digit;
	logic [CB-1:0] ab;
	logic          ab_zero;
	logic          not_sorted;
	logic [TB:0]   total_sum;
	logic [31:0]   line_inc;
	logic [HL-1:0] hdr_inc;
	logic [CB-1:0] seq_inc;
	logic          do_close;
	logic [2:0]    close_kind;
	logic [2:0]    kind;
	logic [7:0]    sym;
	logic [HL-1:0] hl_w;
	logic [CB-1:0] sl_w;
	logic [CB-1:0] ab_w;
	logic [1:0]    err;

	assign b    = in_word.text_byte;
	assign code = nt_code(b);

	// Abundance digit: acc*10 + d, saturating
	assign acc_mul   = (CB+4)'({acc_q, 3'b000}) + (CB+4)'({acc_q, 1'b0}) + (CB+4)'(b[3:0]);
	assign acc_digit = (|acc_mul[CB+3:CB]) ? '1 : acc_mul[CB-1:0];

	// Record close checks
	assign ab         = (after_us_q && digit_seen_q) ? acc_q : '0;
	assign ab_zero    = (ab == '0);
	assign not_sorted = prev_valid_q && (ab > prev_ab_q);
	assign total_sum  = {1'b0, total_q} + (TB+1)'(seq_cnt_q);

	// Saturating increments
	assign line_inc = (line_q == '1) ? line_q : line_q + 32'd1;
	assign hdr_inc  = (hdr_cnt_q == '1) ? hdr_cnt_q : hdr_cnt_q + HDR_ONE;
	assign seq_inc  = (seq_cnt_q == '1) ? seq_cnt_q : seq_cnt_q + CNT_ONE;

	// Next state and result
	always_comb begin
		mode_d       = mode_q;
		line_start_d = line_start_q;
		hdr_cnt_d    = hdr_cnt_q;
		acc_d        = acc_q;
		after_us_d   = after_us_q;
		digit_seen_d = digit_seen_q;
		seq_cnt_d    = seq_cnt_q;
		prev_ab_d    = prev_ab_q;
		prev_valid_d = prev_valid_q;
		line_d       = line_q;
		rec_d        = rec_q;
		longest_d    = longest_q;
		total_d      = total_q;
		res_valid    = 1'b0;
		kind         = KIND_HEADER;
		sym          = 8'h00;
		hl_w         = '0;
		sl_w         = '0;
		ab_w         = '0;
		err          = ERR_BAD_START;
		do_close     = 1'b0;
		close_kind   = KIND_FILE;

		if (fire && (mode_q != MODE_HALTED)) begin
			if (in_word.end_of_text) begin
				if (mode_q == MODE_FILE_START) begin
					res_valid = 1'b1;
					kind      = KIND_FILE;
					mode_d    = MODE_HALTED;
				end else begin
					do_close   = 1'b1;
					close_kind = KIND_FILE;
				end
			end else begin
				unique case (mode_q)
					MODE_FILE_START: begin
						if (b != CHAR_GT) begin
							res_valid = 1'b1;
							kind      = KIND_ERROR;
							err       = ERR_BAD_START;
							mode_d    = MODE_HALTED;
						end else begin
							hdr_cnt_d    = '0;
							acc_d        = '0;
							after_us_d   = 1'b0;
							digit_seen_d = 1'b0;
							seq_cnt_d    = '0;
							mode_d       = MODE_HEADER_ID;
						end
					end
					MODE_HEADER_ID: begin
						if ((b == CHAR_SPACE) || (b == CHAR_NUL)) begin
							mode_d = MODE_HEADER_REST;
						end else if (b == CHAR_NL) begin
							mode_d       = MODE_SEQ;
							line_d       = line_inc;
							line_start_d = 1'b1;
						end else begin
							res_valid = 1'b1;
							kind      = KIND_HEADER;
							sym       = b;
							hdr_cnt_d = hdr_inc;
							priority if (b == CHAR_UNDERSCORE) begin
								after_us_d   = 1'b1;
								digit_seen_d = 1'b0;
								acc_d        = '0;
							end else if ((b >= CHAR_ZERO) && (b <= CHAR_NINE) && after_us_q) begin
								acc_d        = acc_digit;
								digit_seen_d = 1'b1;
							end else begin
								after_us_d   = 1'b0;
								digit_seen_d = 1'b0;
								acc_d        = '0;
							end
						end
					end
					MODE_HEADER_REST, MODE_SEQ_SKIP: begin
						if (b == CHAR_NL) begin
							mode_d       = MODE_SEQ;
							line_d       = line_inc;
							line_start_d = 1'b1;
						end
					end
					MODE_SEQ: begin
						priority if (line_start_q && (b == CHAR_GT)) begin
							do_close   = 1'b1;
							close_kind = KIND_RECORD;
						end else if (b == CHAR_NL) begin
							line_d       = line_inc;
							line_start_d = 1'b1;
						end else if (b == CHAR_NUL) begin
							line_start_d = 1'b0;
							mode_d       = MODE_SEQ_SKIP;
						end else if (code == NT_NONE) begin
							line_start_d = 1'b0;
							res_valid    = 1'b1;
							kind         = KIND_ERROR;
							err          = ERR_ILLEGAL;
							mode_d       = MODE_HALTED;
						end else begin
							line_start_d = 1'b0;
							seq_cnt_d    = seq_inc;
							res_valid    = 1'b1;
							kind         = KIND_NT;
							sym          = {5'b00000, code};
						end
					end
					default: begin
					end
				endcase
			end
		end

		// Close the open record: checks, totals, then next header or halt
		if (do_close) begin
			res_valid = 1'b1;
			hl_w      = hdr_cnt_q;
			sl_w      = seq_cnt_q;
			ab_w      = ab;
			priority if (ab_zero) begin
				kind   = KIND_ERROR;
				err    = ERR_MISSING_AB;
				mode_d = MODE_HALTED;
			end else if (not_sorted) begin
				kind   = KIND_ERROR;
				err    = ERR_NOT_SORTED;
				mode_d = MODE_HALTED;
			end else begin
				kind         = close_kind;
				err          = ERR_BAD_START;
				prev_ab_d    = ab;
				prev_valid_d = 1'b1;
				rec_d        = (rec_q == '1) ? rec_q : rec_q + CNT_ONE;
				longest_d    = (seq_cnt_q > longest_q) ? seq_cnt_q : longest_q;
				total_d      = total_sum[TB] ? '1 : total_sum[TB-1:0];
				if (close_kind == KIND_FILE) begin
					mode_d = MODE_HALTED;
				end else begin
					hdr_cnt_d    = '0;
					acc_d        = '0;
					after_us_d   = 1'b0;
					digit_seen_d = 1'b0;
					seq_cnt_d    = '0;
					mode_d       = MODE_HEADER_ID;
				end
			end
		end

		// Result word; running totals as left by this byte
		res.kind              = kind;
		res.symbol            = sym;
		res.header_length     = hl_w;
		res.sequence_length   = sl_w;
		res.abundance         = ab_w;
		res.record_count      = rec_d;
		res.longest_length    = longest_d;
		res.total_nucleotides = total_d;
		res.error_code        = (kind == KIND_ERROR) ? err : ERR_BAD_START;
		res.line_number       = line_q;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_FILE_START;
			line_start_q <= 1'b1;
			hdr_cnt_q    <= '0;
			acc_q        <= '0;
			after_us_q   <= 1'b0;
			digit_seen_q <= 1'b0;
			seq_cnt_q    <= '0;
			prev_ab_q    <= '0;
			prev_valid_q <= 1'b0;
			line_q       <= 32'd1;
			rec_q        <= '0;
			longest_q    <= '0;
			total_q      <= '0;
		end else begin
			mode_q       <= mode_d;
			line_start_q <= line_start_d;
			hdr_cnt_q    <= hdr_cnt_d;
			acc_q        <= acc_d;
			after_us_q   <= after_us_d;
			digit_seen_q <= digit_seen_d;
			seq_cnt_q    <= seq_cnt_d;
			prev_ab_q    <= prev_ab_d;
			prev_valid_q <= prev_valid_d;
			line_q       <= line_d;
			rec_q        <= rec_d;
			longest_q    <= longest_d;
			total_q      <= total_d;
		end
	end

	// Once halted, nothing restarts the parser short of reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_HALTED) |=> (mode_q == MODE_HALTED))
		else $error("parser left halted mode");

	// Every error word halts the parser
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.kind == KIND_ERROR)) |=> (mode_q == MODE_HALTED))
		else $error("error reported without halting");

	// A clean record close bumps the record count unless it is saturated
	a_record_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.kind == KIND_RECORD))
		|=> ((rec_q != $past(rec_q)) || ($past(rec_q) == '1)))
		else $error("record closed without being counted");

endmodule

`default_nettype wire

>>> design/fnp_out_skid.sv
// fnp_out_skid: two-entry result buffer (output register plus skid register).
// Depends on fnp_pkg for the result word type.
`default_nettype none

module fnp_out_skid import fnp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire fnp_out_t push_word,
	output logic          space,
	output logic          out_valid,
	input  wire logic     out_ready,
	output fnp_out_t      out_word
);

	logic     out_valid_q;
	fnp_out_t out_q;
	logic     skid_valid_q;
	fnp_out_t skid_q;
	logic     drain;

	// Upstream may push while the skid register is free
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign drain     = !out_valid_q || out_ready;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_valid_q ? skid_q : push_word;
		end else if (push) begin
			skid_q <= push_word;
		end
	end

	// The skid register only fills behind a stalled output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");

endmodule

`default_nettype wire

>>> design/fasta_nucleotide_stream_parser.sv
// fasta_nucleotide_stream_parser: top level of the FASTA byte-stream parser.
// Depends on fnp_pkg, fnp_parse_core and fnp_out_skid.
//
//   channel  | direction | handshake           | word
//   ---------+-----------+---------------------+----------------------------
//   in       | input     | in_valid / in_ready | fnp_in_t: text byte, end flag
//   out      | output    | out_valid/out_ready | fnp_out_t: kind, symbol, stats
//
// One text byte per cycle while in_ready is high; each result is registered in the output buffer before out.
// The parser state is a single register stage updated by one byte's logic.
// A two-word output buffer keeps in_ready high through a one-word output stall.
// in_ready drops only while both buffer words are held; it is a register.
// arst_n clears the parser to file start, line 1, all counters zero.
`default_nettype none

module fasta_nucleotide_stream_parser import fnp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire fnp_in_t  in_word,
	output logic          out_valid,
	input  wire logic     out_ready,
	output fnp_out_t      out_word
);

	logic     fire;
	logic     res_valid;
	fnp_out_t res;
	logic     space;

	assign in_ready = space;
	assign fire     = in_valid && in_ready;

	// Byte parser
	fnp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.in_word   (in_word),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result buffer
	fnp_out_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_word (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire
